>>> src/bstk_pkg.sv
// shared types, constants and codes for the bounded stack block
`default_nettype none
package bstk_pkg;

    // stack geometry
    localparam int DEPTH  = 8;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // operation codes
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PAL  = 2'd2;
    localparam logic [1:0] OP_DSP  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // result selection codes for the output register
    localparam logic [2:0] RES_OK    = 3'd0;
    localparam logic [2:0] RES_FULL  = 3'd1;
    localparam logic [2:0] RES_EMPTY = 3'd2;
    localparam logic [2:0] RES_POP   = 3'd3;
    localparam logic [2:0] RES_DSP   = 3'd4;
    localparam logic [2:0] RES_PAL   = 3'd5;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data;
        logic                     is_palindrome;
        logic                     last;
    } rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       push_wr;
        logic       pop_rd;
        logic       pal_init;
        logic       pal_rd;
        logic       pal_cmp;
        logic       dsp_init;
        logic       dsp_step;
        logic       emit;
        logic [2:0] res_sel;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       empty;
        logic       full;
        logic       pal_done;
        logic       dsp_last;
    } dp_sts_t;

endpackage
`default_nettype wire

>>> src/bstk_dp.sv
// stack datapath: entry memory, count, walk pointers and output register
`default_nettype none
module bstk_dp
    import bstk_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire req_t    req,
    input  wire dp_cmd_t cmd,
    output dp_sts_t      sts,
    output rsp_t         rsp
);

    logic signed [DATA_W-1:0] mem [DEPTH];

    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [1:0]               op_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [ADDR_W-1:0]        lo_reg, lo_next;
    logic [ADDR_W-1:0]        hi_reg, hi_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic                     match_reg, match_next;
    logic signed [DATA_W-1:0] rd_a_reg, rd_b_reg;
    rsp_t                     rsp_reg, rsp_next;

    logic [CNT_W-1:0]         cnt_m1;
    logic [ADDR_W-1:0]        top_addr;
    logic [ADDR_W-1:0]        idx_m1;
    logic [ADDR_W-1:0]        rd_a_addr;
    logic                     rd_a_en;

    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign top_addr = cnt_m1[ADDR_W-1:0];
    assign idx_m1   = idx_reg - ADDR_W'(1);

    // status toward the controller
    always_comb
    begin
        sts.op       = op_reg;
        sts.empty    = (cnt_reg == '0);
        sts.full     = (cnt_reg == CNT_W'(DEPTH));
        sts.pal_done = (lo_reg >= hi_reg);
        sts.dsp_last = (idx_reg == '0);
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req.op;
            val_reg <= req.value;
        end
    end

    // stack depth counter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.push_wr)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (cmd.pop_rd)
        begin
            cnt_next = cnt_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // walk pointers for mirror compare and display
    always_comb
    begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        match_next = match_reg;
        if (cmd.pal_init)
        begin
            lo_next    = '0;
            hi_next    = top_addr;
            match_next = 1'b1;
        end
        if (cmd.pal_cmp)
        begin
            lo_next    = lo_reg + ADDR_W'(1);
            hi_next    = hi_reg - ADDR_W'(1);
            match_next = match_reg & (rd_a_reg == rd_b_reg);
        end
        if (cmd.dsp_init)
        begin
            idx_next = top_addr;
        end
        else if (cmd.dsp_step)
        begin
            idx_next = idx_m1;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        idx_reg   <= idx_next;
        match_reg <= match_next;
    end

    // read port a address select
    always_comb
    begin
        rd_a_en   = cmd.pal_rd | cmd.pop_rd | cmd.dsp_init | cmd.dsp_step;
        rd_a_addr = top_addr;
        if (cmd.pal_rd)
        begin
            rd_a_addr = lo_reg;
        end
        else if (cmd.dsp_step)
        begin
            rd_a_addr = idx_m1;
        end
    end

    // entry memory, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.push_wr)
        begin
            mem[cnt_reg[ADDR_W-1:0]] <= val_reg;
        end
        if (rd_a_en)
        begin
            rd_a_reg <= mem[rd_a_addr];
        end
        if (cmd.pal_rd)
        begin
            rd_b_reg <= mem[hi_reg];
        end
    end

    // result beat formatting
    always_comb
    begin
        rsp_next               = rsp_reg;
        rsp_next.data          = '0;
        rsp_next.is_palindrome = 1'b0;
        rsp_next.last          = 1'b1;
        case (cmd.res_sel)
            RES_OK:
            begin
                rsp_next.status = ST_OK;
            end
            RES_FULL:
            begin
                rsp_next.status = ST_FULL;
            end
            RES_EMPTY:
            begin
                rsp_next.status = ST_EMPTY;
            end
            RES_POP:
            begin
                rsp_next.status = ST_OK;
                rsp_next.data   = rd_a_reg;
            end
            RES_DSP:
            begin
                rsp_next.status = ST_OK;
                rsp_next.data   = rd_a_reg;
                rsp_next.last   = (idx_reg == '0);
            end
            RES_PAL:
            begin
                rsp_next.status        = ST_OK;
                rsp_next.is_palindrome = match_reg;
            end
            default:
            begin
                rsp_next.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule
`default_nettype wire

>>> src/bstk_ctrl.sv
// stack controller: operation sequencing and output handshake
`default_nettype none
module bstk_ctrl
    import bstk_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_ready,
    output logic         rsp_valid,
    input  wire logic    rsp_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_POP_OUT = 3'd2;
    localparam logic [2:0] S_PAL_RD  = 3'd3;
    localparam logic [2:0] S_PAL_CMP = 3'd4;
    localparam logic [2:0] S_PAL_OUT = 3'd5;
    localparam logic [2:0] S_DSP_OUT = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    // output slot is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_sel = RES_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (sts.op)
                    OP_PUSH:
                    begin
                        if (slot_free)
                        begin
                            cmd.emit    = 1'b1;
                            cmd.res_sel = sts.full ? RES_FULL : RES_OK;
                            cmd.push_wr = !sts.full;
                            state_next  = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (sts.empty)
                        begin
                            if (slot_free)
                            begin
                                cmd.emit    = 1'b1;
                                cmd.res_sel = RES_EMPTY;
                                state_next  = S_IDLE;
                            end
                        end
                        else if (sts.op == OP_POP)
                        begin
                            cmd.pop_rd = 1'b1;
                            state_next = S_POP_OUT;
                        end
                        else if (sts.op == OP_PAL)
                        begin
                            cmd.pal_init = 1'b1;
                            state_next   = S_PAL_RD;
                        end
                        else
                        begin
                            cmd.dsp_init = 1'b1;
                            state_next   = S_DSP_OUT;
                        end
                    end
                endcase
            end
            S_POP_OUT:
            begin
                if (slot_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.res_sel = RES_POP;
                    state_next  = S_IDLE;
                end
            end
            S_PAL_RD:
            begin
                if (sts.pal_done)
                begin
                    state_next = S_PAL_OUT;
                end
                else
                begin
                    cmd.pal_rd = 1'b1;
                    state_next = S_PAL_CMP;
                end
            end
            S_PAL_CMP:
            begin
                cmd.pal_cmp = 1'b1;
                state_next  = S_PAL_RD;
            end
            S_PAL_OUT:
            begin
                if (slot_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.res_sel = RES_PAL;
                    state_next  = S_IDLE;
                end
            end
            S_DSP_OUT:
            begin
                // emit the current entry and fetch the one below in the same cycle
                if (slot_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.res_sel = RES_DSP;
                    if (sts.dsp_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.dsp_step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

>>> src/bounded_stack_with_palindrome_check.sv
// Bounded LIFO stack of signed 32-bit words with mirror check and display.
// The req channel carries one operation per beat (push, pop, palindrome
// check, display); the rsp channel returns status, data, a palindrome
// flag and a last flag. Both are valid/ready channels.
// One operation is in work at a time; req_ready is high while the
// sequencer is idle, even while a finished beat waits on rsp.
// After a req is accepted, a push or any operation on an empty stack is
// answered from the execute state; a pop reads the top entry and answers
// from its output state; a palindrome check alternates read and compare
// states, one compare per read of both memory ports; a display reads the
// top entry, then sends one beat per cycle from top to bottom while rsp does
// not stall, as read port a walks the entries. No new request is taken until
// the last one is finished, so req_ready stays low through a whole display.
// When the receiver stalls, the finished beat is held in the output
// register and the sequencer waits before producing the next one; no
// beat is lost or repeated.
// Reset clears the count and the handshake state at once; the stack
// comes up empty with no clearing pass and accepts a beat right away.
`default_nettype none
module bounded_stack_with_palindrome_check
    import bstk_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer
    bstk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // storage and result formatting
    bstk_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule
`default_nettype wire

>>> src/bstk_chk.sv
// port-level checker for the bounded stack, bound to the top level
`default_nettype none
module bstk_chk
    import bstk_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp
);

    // a stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp beat dropped or changed while stalled");

    // error results are single beats with no data
    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |->
            rsp.last && rsp.data == '0 && !rsp.is_palindrome)
        else $error("error result carries data or is not last");

    // palindrome flag only on an ok single beat without data
    a_pal_beat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_palindrome |->
            rsp.status == ST_OK && rsp.last && rsp.data == '0)
        else $error("palindrome flag on a malformed beat");

    // one operation at a time: ready drops after each accepted request
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken while one is in work");

endmodule

bind bounded_stack_with_palindrome_check bstk_chk u_bstk_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
`default_nettype wire

>>> sim/tb.sv
// testbench for the bounded stack with palindrome check
`timescale 1ns / 1ps
module tb;
    import bstk_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 430;
    localparam int CALM_TAIL   = 60;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    bounded_stack_with_palindrome_check dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // requests waiting to be driven and responses still owed by the block
    req_t pending_reqs[$];
    rsp_t owed_rsps[$];

    // shadow stack contents
    logic signed [DATA_W-1:0] shadow_stack[DEPTH];
    int unsigned              shadow_count;

    // fill level as seen while building the stimulus
    int unsigned gen_count;

    int fails;
    int cycles;
    int beats_sent;
    int beats_checked;
    int n_push_ok, n_full, n_pop_ok, n_empty, n_pal_yes, n_pal_no, n_dsp_beats;

    int gap_left;
    int stall_left;

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // update the shadow stack for one accepted request and queue its responses
    task automatic predict_stack_op(input req_t r);
        rsp_t        e;
        logic        mirror;
        int          lo;
        int          hi;
        int          i;
        e = '0;
        e.last = 1'b1;
        case (r.op)
            OP_PUSH:
            begin
                if (shadow_count >= DEPTH)
                begin
                    e.status = ST_FULL;
                    n_full++;
                end
                else
                begin
                    shadow_stack[shadow_count] = r.value;
                    shadow_count++;
                    e.status = ST_OK;
                    n_push_ok++;
                end
                owed_rsps.push_back(e);
            end
            OP_POP:
            begin
                if (shadow_count == 0)
                begin
                    e.status = ST_EMPTY;
                    n_empty++;
                end
                else
                begin
                    shadow_count--;
                    e.status = ST_OK;
                    e.data = shadow_stack[shadow_count];
                    n_pop_ok++;
                end
                owed_rsps.push_back(e);
            end
            OP_PAL:
            begin
                if (shadow_count == 0)
                begin
                    e.status = ST_EMPTY;
                    n_empty++;
                end
                else
                begin
                    mirror = 1'b1;
                    lo = 0;
                    hi = shadow_count - 1;
                    while (lo < hi)
                    begin
                        if (shadow_stack[lo] != shadow_stack[hi])
                            mirror = 1'b0;
                        lo++;
                        hi--;
                    end
                    e.status = ST_OK;
                    e.is_palindrome = mirror;
                    if (mirror)
                        n_pal_yes++;
                    else
                        n_pal_no++;
                end
                owed_rsps.push_back(e);
            end
            default:
            begin
                if (shadow_count == 0)
                begin
                    e.status = ST_EMPTY;
                    n_empty++;
                    owed_rsps.push_back(e);
                end
                else
                begin
                    // walk from top to bottom, last flag on the bottom entry
                    for (i = shadow_count - 1; i >= 0; i--)
                    begin
                        e = '0;
                        e.status = ST_OK;
                        e.data = shadow_stack[i];
                        e.last = (i == 0);
                        owed_rsps.push_back(e);
                        n_dsp_beats++;
                    end
                end
            end
        endcase
    endtask

    // append one request to the stimulus and track the fill level
    task automatic queue_request(input logic [1:0] op, input logic [DATA_W-1:0] value);
        req_t r;
        r.op = op;
        r.value = value;
        pending_reqs.push_back(r);
        if (op == OP_PUSH && gen_count < DEPTH)
            gen_count++;
        else if (op == OP_POP && gen_count > 0)
            gen_count--;
    endtask

    // word with a bias toward extremes and repeated small values
    function automatic logic [DATA_W-1:0] pick_word();
        logic [DATA_W-1:0] w;
        case ($urandom_range(0, 5))
            0: w = 32'h8000_0000;
            1: w = 32'h7fff_ffff;
            2: w = 32'hffff_ffff;
            3: w = $urandom_range(0, 3);
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // stimulus
    initial
    begin : build_stimulus
        logic [DATA_W-1:0] half[DEPTH];
        logic [DATA_W-1:0] seq[DEPTH];
        int                len;
        int                k;
        int                n;
        int                spot;
        logic [1:0]        op;

        gen_count = 0;

        // empty stack cases
        queue_request(OP_DSP, 32'h1234_5678);
        queue_request(OP_POP, 32'hffff_ffff);
        queue_request(OP_PAL, 32'h0);
        // extremes, a two-entry mismatch, then a three-entry mirror
        queue_request(OP_PUSH, 32'h8000_0000);
        queue_request(OP_PUSH, 32'h7fff_ffff);
        queue_request(OP_PAL, 32'h0);
        queue_request(OP_PUSH, 32'h8000_0000);
        queue_request(OP_PAL, 32'h0);
        queue_request(OP_DSP, 32'h0);
        // fill up, then one refused push
        queue_request(OP_PUSH, 32'hffff_ffff);
        queue_request(OP_PUSH, 32'h0);
        queue_request(OP_PUSH, 32'h5555_5555);
        queue_request(OP_PUSH, 32'haaaa_aaaa);
        queue_request(OP_PUSH, 32'h1);
        queue_request(OP_PUSH, 32'h5);
        queue_request(OP_PAL, 32'h0);
        queue_request(OP_DSP, 32'h0);
        queue_request(OP_POP, 32'h0);
        queue_request(OP_POP, 32'h0);

        while (pending_reqs.size() < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    // drain, build a mirrored sequence, maybe spoil it, check it
                    n = gen_count;
                    for (k = 0; k < n; k++)
                        queue_request(OP_POP, $urandom);
                    len = $urandom_range(1, DEPTH);
                    for (k = 0; k < DEPTH; k++)
                        half[k] = pick_word();
                    for (k = 0; k < len; k++)
                        seq[k] = (k < (len + 1) / 2) ? half[k] : half[len - 1 - k];
                    if ($urandom_range(0, 3) == 0)
                    begin
                        spot = $urandom_range(0, len - 1);
                        seq[spot][$urandom_range(0, DATA_W - 1)] ^= 1'b1;
                    end
                    for (k = 0; k < len; k++)
                        queue_request(OP_PUSH, seq[k]);
                    queue_request(OP_PAL, $urandom);
                    if ($urandom_range(0, 1) == 1)
                        queue_request(OP_DSP, $urandom);
                end
                4, 5, 6:
                begin
                    // random operation mix
                    n = $urandom_range(2, 10);
                    for (k = 0; k < n; k++)
                    begin
                        case ($urandom_range(0, 7))
                            0, 1, 2, 3: op = OP_PUSH;
                            4, 5:       op = OP_POP;
                            6:          op = OP_PAL;
                            default:    op = OP_DSP;
                        endcase
                        queue_request(op, pick_word());
                    end
                end
                7, 8:
                begin
                    // push past full
                    n = DEPTH - gen_count + $urandom_range(1, 3);
                    for (k = 0; k < n; k++)
                        queue_request(OP_PUSH, pick_word());
                    queue_request(OP_PAL, $urandom);
                    queue_request(OP_DSP, $urandom);
                end
                default:
                begin
                    // pop past empty
                    n = gen_count + $urandom_range(1, 3);
                    for (k = 0; k < n; k++)
                        queue_request(OP_POP, $urandom);
                    queue_request(OP_PAL, $urandom);
                    queue_request(OP_DSP, $urandom);
                end
            endcase
        end
    end

    // reset
    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid    <= 1'b0;
            req          <= '0;
            gap_left     <= 0;
            shadow_count = 0;
            beats_sent   <= 0;
        end
        else
        begin : drive
            logic accepted;
            logic calm;
            accepted = req_valid && req_ready;
            calm = (pending_reqs.size() < CALM_TAIL) || ((beats_sent / 40) % 3 == 2);
            if (accepted)
            begin
                predict_stack_op(req);
                beats_sent <= beats_sent + 1;
            end
            if (!req_valid || accepted)
            begin
                if (gap_left > 0)
                begin
                    gap_left  <= gap_left - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() == 0)
                    req_valid <= 1'b0;
                else if (!calm && $urandom_range(0, 5) == 0)
                begin
                    gap_left  <= $urandom_range(0, 7);
                    req_valid <= 1'b0;
                end
                else
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
            end
        end
    end

    // response monitor with receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready     <= 1'b0;
            stall_left    <= 0;
            beats_checked <= 0;
            fails         <= 0;
        end
        else
        begin : observe
            rsp_t e;
            logic calm;
            int   bad;
            calm = (pending_reqs.size() < CALM_TAIL) || ((beats_checked / 50) % 3 == 1);
            bad = 0;
            if (rsp_valid && rsp_ready)
            begin
                beats_checked <= beats_checked + 1;
                if (owed_rsps.size() == 0)
                begin
                    $error("unexpected response beat: status %0d data %0d", rsp.status,
                           rsp.data);
                    bad = 1;
                end
                else
                begin
                    e = owed_rsps.pop_front();
                    if (rsp.status !== e.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d", e.status,
                               rsp.status);
                        bad = 1;
                    end
                    if (rsp.data !== e.data)
                    begin
                        $error("data mismatch: expected %0d, actual %0d", e.data, rsp.data);
                        bad = 1;
                    end
                    if (rsp.is_palindrome !== e.is_palindrome)
                    begin
                        $error("is_palindrome mismatch: expected %0d, actual %0d",
                               e.is_palindrome, rsp.is_palindrome);
                        bad = 1;
                    end
                    if (rsp.last !== e.last)
                    begin
                        $error("last mismatch: expected %0d, actual %0d", e.last, rsp.last);
                        bad = 1;
                    end
                end
            end
            fails <= fails + bad;
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                rsp_ready  <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                stall_left <= $urandom_range(0, 7);
                rsp_ready  <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses still owed", cycles,
                     owed_rsps.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial cycles = 0;

    // end of run
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        while (pending_reqs.size() != 0 || req_valid)
            @(posedge clk);
        while (owed_rsps.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("%0d requests, %0d response beats checked: %0d pushes, %0d refused on full,",
                 beats_sent, beats_checked, n_push_ok, n_full);
        $display("%0d pops, %0d empty cases, %0d/%0d mirror yes/no, %0d display beats",
                 n_pop_ok, n_empty, n_pal_yes, n_pal_no, n_dsp_beats);
        if (owed_rsps.size() != 0)
            $error("%0d response beats never arrived", owed_rsps.size());
        if (fails == 0 && owed_rsps.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
src/bstk_pkg.sv
src/bstk_dp.sv
src/bstk_ctrl.sv
src/bounded_stack_with_palindrome_check.sv
src/bstk_chk.sv
sim/tb.sv
